[rtl/assert_macros.svh]
// Assertion macros shared by the rotation-to-Euler RTL.
// Expects signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RMTE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define RMTE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rmte_pkg.sv]
// Package for the rotation-matrix-to-Euler block: widths, register codes,
// the queue entry type and the CORDIC arctangent table. No dependencies.
package rmte_pkg;

   localparam int RW           = 32;   // matrix element, Q2.30
   localparam int NEL          = 9;    // matrix elements
   localparam int PW           = 64;   // element product
   localparam int SW           = 66;   // sum of three products
   localparam int DW           = 22;   // capped identity difference
   localparam int QW           = 2 * DW;
   localparam int EW           = QW + 4; // sum of nine squares
   localparam int TW           = 40;   // tolerance registers
   localparam int SYW          = 64;   // sy squared
   localparam int OW           = RW + 1; // CORDIC operand
   localparam int XW           = OW + 4; // CORDIC vector with growth
   localparam int ACW          = 32;   // angle accumulator
   localparam int AW           = 31;   // result angle, Q3.28
   localparam int CORDIC_STEPS = 24;
   localparam int SQRT_STEPS   = SYW / 2;
   localparam int QDEPTH       = 4;
   localparam int QAW          = $clog2(QDEPTH);
   localparam int QCW          = QAW + 1;
   localparam int CSR_IW       = 8;

   localparam logic [CSR_IW-1:0] CSR_ORTHO_TOL = CSR_IW'(0);
   localparam logic [CSR_IW-1:0] CSR_SING_TOL  = CSR_IW'(1);

   localparam logic [TW-1:0]         TOL_RESET   = TW'(1152922);
   localparam logic signed [ACW-1:0] Q28_PI      = ACW'(843314857);
   localparam logic signed [ACW-1:0] Q28_HALF_PI = ACW'(421657428);
   localparam logic [DW-1:0]         DIFF_CAP    = DW'(2097152);
   localparam logic signed [SW-1:0]  ONE_Q30     = SW'(1073741824);
   localparam logic signed [SW-1:0]  HALF_Q30    = SW'(536870912);

   typedef logic signed [RW-1:0] elem_type;

   // One classified matrix waiting for the angle pipeline
   typedef struct packed {
      logic                  rot;
      logic                  sing;
      logic [SYW-1:0]        sy2;
      logic signed [OW-1:0]  ay_y;
      logic signed [OW-1:0]  ax_y;
      logic signed [OW-1:0]  ax_x;
      logic signed [OW-1:0]  az_y;
      logic signed [OW-1:0]  az_x;
   } job_type;

   // round(atan(2^-i) * 2^28)
   function automatic logic signed [ACW-1:0] atan_lut(input int unsigned i);
      logic signed [ACW-1:0] t;
      unique case (i)
         0:  t = ACW'(210828714);
         1:  t = ACW'(124459457);
         2:  t = ACW'(65760959);
         3:  t = ACW'(33381290);
         4:  t = ACW'(16755422);
         5:  t = ACW'(8385879);
         6:  t = ACW'(4193963);
         7:  t = ACW'(2097109);
         8:  t = ACW'(1048571);
         9:  t = ACW'(524287);
         10: t = ACW'(262144);
         11: t = ACW'(131072);
         12: t = ACW'(65536);
         13: t = ACW'(32768);
         14: t = ACW'(16384);
         15: t = ACW'(8192);
         16: t = ACW'(4096);
         17: t = ACW'(2048);
         18: t = ACW'(1024);
         19: t = ACW'(512);
         20: t = ACW'(256);
         21: t = ACW'(128);
         22: t = ACW'(64);
         23: t = ACW'(32);
         24: t = ACW'(16);
         25: t = ACW'(8);
         26: t = ACW'(4);
         27: t = ACW'(2);
         28: t = ACW'(1);
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

[rtl/rmte_intf.sv]
// Channel interfaces of the rotation-to-Euler block: matrix input, angle
// result and register write. Depends on rmte_pkg.
interface rmte_req_if;
   import rmte_pkg::*;
   logic     valid;
   logic     ready;
   elem_type r00, r01, r02, r10, r11, r12, r20, r21, r22;
   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   input ready);
   modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                 output ready);
endinterface

interface rmte_rsp_if;
   import rmte_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 is_rotation;
   logic                 singular;
   logic signed [AW-1:0] angle_x;
   logic signed [AW-1:0] angle_y;
   logic signed [AW-1:0] angle_z;
   modport source (output valid, is_rotation, singular, angle_x, angle_y, angle_z,
                   input ready);
   modport sink (input valid, is_rotation, singular, angle_x, angle_y, angle_z,
                 output ready);
endinterface

interface rmte_csr_if;
   import rmte_pkg::*;
   logic              valid;
   logic              ready;
   logic [CSR_IW-1:0] index;
   logic [TW-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/rotation_matrix_to_euler_angles.sv]
// Rotation matrix to XYZ Euler angles.
// Channels: req_ch takes one 3x3 matrix of signed Q2.30 elements per
// transaction; rsp_ch returns one transaction per matrix with is_rotation,
// singular and angle_x/y/z in signed Q3.28 radians; csr_ch writes the two
// 40-bit tolerance registers (index 0 orthogonality, 1 singular threshold)
// and is always ready; write it only while no matrix is in flight.
// Path: the matrix passes 62 registers: 4 front stages (products, rounding,
// squares, error sum), one queue entry, 32 square root stages, 24 CORDIC
// stages and the result register.
// Throughput: one matrix per cycle while no result is held; every stage is a
// separate register, the three arctangents run in parallel CORDIC pipelines.
// Reset: synchronous; empties the pipelines and queue and loads both
// tolerances with 1152922 (1e-12 in Q60). No memories to clear.
// Stall: while a result waits, the back pipeline holds; the front keeps
// taking matrices until the four-entry queue fills, then req_ch.ready drops.
// Depends on rmte_pkg, rmte_intf, rmte_front, rmte_queue, rmte_back.
module rotation_matrix_to_euler_angles (
   input  logic       clock,
   input  logic       reset,
   rmte_req_if.sink   req_ch,
   rmte_rsp_if.source rsp_ch,
   rmte_csr_if.sink   csr_ch
);
   import rmte_pkg::*;

   logic [TW-1:0] ortho_tol_ff, sing_tol_ff;
   logic          fq_valid, fq_ready, qb_valid, qb_ready;
   job_type       fq_job, qb_job;

   assign csr_ch.ready = 1'b1;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         ortho_tol_ff <= TOL_RESET;
         sing_tol_ff  <= TOL_RESET;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == CSR_ORTHO_TOL) begin
            ortho_tol_ff <= csr_ch.data;
         end else if (csr_ch.index == CSR_SING_TOL) begin
            sing_tol_ff <= csr_ch.data;
         end
      end
   end

   rmte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .ortho_tol (ortho_tol_ff),
      .sing_tol  (sing_tol_ff),
      .job_valid (fq_valid),
      .job       (fq_job),
      .job_ready (fq_ready)
   );

   rmte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_job),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_job)
   );

   rmte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job       (qb_job),
      .rsp_ch    (rsp_ch)
   );

endmodule

[rtl/rmte_front.sv]
// Front part: accepts matrices, runs the orthogonality check and the
// singular-case test, and builds one queue entry. Depends on rmte_pkg.
`include "assert_macros.svh"
module rmte_front (
   input  logic                  clock,
   input  logic                  reset,
   rmte_req_if.sink              req_ch,
   input  logic [rmte_pkg::TW-1:0] ortho_tol,
   input  logic [rmte_pkg::TW-1:0] sing_tol,
   output logic                  job_valid,
   output rmte_pkg::job_type     job,
   input  logic                  job_ready
);
   import rmte_pkg::*;

   elem_type              r_in [NEL];
   logic                  en;

   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic signed [PW-1:0]  prod_ff [NEL][3];
   elem_type              r1_ff [NEL];
   elem_type              r2_ff [NEL];
   elem_type              r3_ff [NEL];
   logic [DW-1:0]         dif_in [NEL];
   logic [DW-1:0]         dif_ff [NEL];
   logic [SYW-1:0]        sy2_in, sy2_ff, sy2_3_ff;
   logic [QW-1:0]         sq_ff [NEL];
   logic [EW-1:0]         err_in;
   job_type               job_in, job_ff;

   assign r_in[0] = req_ch.r00;
   assign r_in[1] = req_ch.r01;
   assign r_in[2] = req_ch.r02;
   assign r_in[3] = req_ch.r10;
   assign r_in[4] = req_ch.r11;
   assign r_in[5] = req_ch.r12;
   assign r_in[6] = req_ch.r20;
   assign r_in[7] = req_ch.r21;
   assign r_in[8] = req_ch.r22;

   // Advance the whole front unless its last stage is held by a full queue
   assign en           = !s4_valid_ff || job_ready;
   assign req_ch.ready = en;
   assign job_valid    = s4_valid_ff;
   assign job          = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_ch.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Element (i,j) of R'R needs column products r[k][i] * r[k][j]
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               for (int k = 0; k < 3; k++) begin
                  prod_ff[i*3+j][k] <= PW'(r_in[k*3+i]) * PW'(r_in[k*3+j]);
               end
            end
         end
         r1_ff <= r_in;
      end
   end

   // Round each element to Q30, take the difference from identity, cap it
   always_comb begin
      logic signed [SW-1:0] sum_v;
      logic signed [SW-1:0] rnd_v;
      logic signed [SW-1:0] mag_v;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sum_v = SW'(prod_ff[i*3+j][0]) + SW'(prod_ff[i*3+j][1])
                    + SW'(prod_ff[i*3+j][2]);
            rnd_v = (sum_v + HALF_Q30) >>> 30;
            if (i == j) begin
               rnd_v = rnd_v - ONE_Q30;
            end
            mag_v = (rnd_v < 0) ? -rnd_v : rnd_v;
            dif_in[i*3+j] = (mag_v >= SW'(DIFF_CAP)) ? DIFF_CAP : mag_v[DW-1:0];
         end
      end
   end

   // r00^2 + r10^2 are the first two products of element (0,0)
   assign sy2_in = SYW'(prod_ff[0][0]) + SYW'(prod_ff[0][1]);

   always_ff @(posedge clock) begin
      if (en) begin
         dif_ff <= dif_in;
         sy2_ff <= sy2_in;
         r2_ff  <= r1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int e = 0; e < NEL; e++) begin
            sq_ff[e] <= QW'(dif_ff[e]) * QW'(dif_ff[e]);
         end
         sy2_3_ff <= sy2_ff;
         r3_ff    <= r2_ff;
      end
   end

   // Sum the squared errors, decide rotation and singular case, pick operands
   always_comb begin
      err_in = '0;
      for (int e = 0; e < NEL; e++) begin
         err_in = err_in + EW'(sq_ff[e]);
      end
      job_in.rot  = err_in < EW'(ortho_tol);
      job_in.sing = sy2_3_ff < SYW'(sing_tol);
      job_in.sy2  = sy2_3_ff;
      job_in.ay_y = -OW'(r3_ff[6]);
      job_in.ax_y = job_in.sing ? -OW'(r3_ff[5]) : OW'(r3_ff[7]);
      job_in.ax_x = job_in.sing ? OW'(r3_ff[4]) : OW'(r3_ff[8]);
      job_in.az_y = OW'(r3_ff[3]);
      job_in.az_x = OW'(r3_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         job_ff <= job_in;
      end
   end

   `RMTE_ASSERT_IMP(a_front_stall_cause, !req_ch.ready, s4_valid_ff && !job_ready, "front stalled without a held entry")

endmodule

[rtl/rmte_queue.sv]
// Short queue between the front and back parts, kept in flops.
// Depends on rmte_pkg.
`include "assert_macros.svh"
module rmte_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rmte_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output rmte_pkg::job_type pop_data
);
   import rmte_pkg::*;

   job_type        entry_ff [QDEPTH];
   logic [QAW-1:0] wptr_ff, rptr_ff;
   logic [QCW-1:0] count_ff;
   logic           push, pop;

   assign push_ready = count_ff != QCW'(QDEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Track pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

   `RMTE_ASSERT_NEXT(a_queue_fill, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not rise on push")

endmodule

[rtl/rmte_cordic.sv]
// Pipelined CORDIC arctangent in vectoring mode, one iteration per stage.
// Depends on rmte_pkg.
module rmte_cordic (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [rmte_pkg::OW-1:0] vec_y,
   input  logic signed [rmte_pkg::OW-1:0] vec_x,
   output logic signed [rmte_pkg::AW-1:0] angle
);
   import rmte_pkg::*;

   logic signed [XW-1:0]  x0, y0;
   logic signed [ACW-1:0] a0;
   logic                  z0;
   logic signed [XW-1:0]  x_ff [CORDIC_STEPS];
   logic signed [XW-1:0]  y_ff [CORDIC_STEPS];
   logic signed [ACW-1:0] acc_ff [CORDIC_STEPS];
   logic                  zero_ff [CORDIC_STEPS];
   logic signed [ACW-1:0] acc_last;

   // Turn a left-half vector by a quarter turn first
   always_comb begin
      z0 = (vec_x == '0) && (vec_y == '0);
      x0 = XW'(vec_x);
      y0 = XW'(vec_y);
      a0 = '0;
      if (vec_x < 0) begin
         if (vec_y >= 0) begin
            x0 = XW'(vec_y);
            y0 = -XW'(vec_x);
            a0 = Q28_HALF_PI;
         end else begin
            x0 = -XW'(vec_y);
            y0 = XW'(vec_x);
            a0 = -Q28_HALF_PI;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      logic signed [XW-1:0]  xi, yi;
      logic signed [ACW-1:0] ai;
      logic                  zi;
      if (i == 0) begin : g_first
         assign xi = x0;
         assign yi = y0;
         assign ai = a0;
         assign zi = z0;
      end else begin : g_next
         assign xi = x_ff[i-1];
         assign yi = y_ff[i-1];
         assign ai = acc_ff[i-1];
         assign zi = zero_ff[i-1];
      end
      // Rotate toward the x axis by the sign of y
      always_ff @(posedge clock) begin
         if (en) begin
            if (yi >= 0) begin
               x_ff[i]   <= xi + (yi >>> i);
               y_ff[i]   <= yi - (xi >>> i);
               acc_ff[i] <= ai + atan_lut(i);
            end else begin
               x_ff[i]   <= xi - (yi >>> i);
               y_ff[i]   <= yi + (xi >>> i);
               acc_ff[i] <= ai - atan_lut(i);
            end
            zero_ff[i] <= zi;
         end
      end
   end

   // Saturate to plus or minus pi; a zero vector gives zero
   always_comb begin
      acc_last = acc_ff[CORDIC_STEPS-1];
      if (acc_last > Q28_PI) begin
         acc_last = Q28_PI;
      end else if (acc_last < -Q28_PI) begin
         acc_last = -Q28_PI;
      end
      angle = zero_ff[CORDIC_STEPS-1] ? '0 : acc_last[AW-1:0];
   end

endmodule

[rtl/rmte_back.sv]
// Back part: square root of sy squared, three CORDIC arctangents and the
// result register. Depends on rmte_pkg and rmte_cordic.
`include "assert_macros.svh"
module rmte_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  rmte_pkg::job_type job,
   rmte_rsp_if.source        rsp_ch
);
   import rmte_pkg::*;

   logic                 en;
   logic                 sv_ff [SQRT_STEPS];
   logic [SYW-1:0]       rem_ff [SQRT_STEPS];
   logic [SYW-1:0]       root_ff [SQRT_STEPS];
   job_type              jb_ff [SQRT_STEPS];
   job_type              jl;
   logic signed [OW-1:0] sy;
   logic signed [AW-1:0] ang_x, ang_y, ang_z;
   logic                 cv_ff [CORDIC_STEPS];
   logic                 crot_ff [CORDIC_STEPS];
   logic                 csing_ff [CORDIC_STEPS];
   logic                 rsp_valid_ff, rsp_rot_ff, rsp_sing_ff;
   logic signed [AW-1:0] rsp_ax_ff, rsp_ay_ff, rsp_az_ff;

   // Advance everything unless a finished result is held
   assign en        = !rsp_valid_ff || rsp_ch.ready;
   assign job_ready = en;

   // Integer square root, one result bit per stage
   for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
      localparam logic [SYW-1:0] BIT = SYW'(1) << (2 * (SQRT_STEPS - 1 - s));
      logic           vi;
      logic [SYW-1:0] remi, rooti, trial;
      job_type        ji;
      if (s == 0) begin : g_first
         assign vi    = job_valid;
         assign remi  = job.sy2;
         assign rooti = '0;
         assign ji    = job;
      end else begin : g_next
         assign vi    = sv_ff[s-1];
         assign remi  = rem_ff[s-1];
         assign rooti = root_ff[s-1];
         assign ji    = jb_ff[s-1];
      end
      assign trial = rooti + BIT;
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[s] <= 1'b0;
         end else if (en) begin
            sv_ff[s] <= vi;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (remi >= trial) begin
               rem_ff[s]  <= remi - trial;
               root_ff[s] <= (rooti >> 1) + BIT;
            end else begin
               rem_ff[s]  <= remi;
               root_ff[s] <= rooti >> 1;
            end
            jb_ff[s] <= ji;
         end
      end
   end

   assign jl = jb_ff[SQRT_STEPS-1];
   assign sy = root_ff[SQRT_STEPS-1][OW-1:0];

   rmte_cordic u_cordic_x (
      .clock (clock),
      .en    (en),
      .vec_y (jl.ax_y),
      .vec_x (jl.ax_x),
      .angle (ang_x)
   );

   rmte_cordic u_cordic_y (
      .clock (clock),
      .en    (en),
      .vec_y (jl.ay_y),
      .vec_x (sy),
      .angle (ang_y)
   );

   rmte_cordic u_cordic_z (
      .clock (clock),
      .en    (en),
      .vec_y (jl.az_y),
      .vec_x (jl.az_x),
      .angle (ang_z)
   );

   // Carry valid and flags alongside the CORDIC stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            cv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         cv_ff[0] <= sv_ff[SQRT_STEPS-1];
         for (int i = 1; i < CORDIC_STEPS; i++) begin
            cv_ff[i] <= cv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         crot_ff[0]  <= jl.rot;
         csing_ff[0] <= jl.sing;
         for (int i = 1; i < CORDIC_STEPS; i++) begin
            crot_ff[i]  <= crot_ff[i-1];
            csing_ff[i] <= csing_ff[i-1];
         end
      end
   end

   // Result register; a non-rotation reports all zeros, a singular one a zero z angle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= cv_ff[CORDIC_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_rot_ff  <= crot_ff[CORDIC_STEPS-1];
         rsp_sing_ff <= crot_ff[CORDIC_STEPS-1] && csing_ff[CORDIC_STEPS-1];
         rsp_ax_ff   <= crot_ff[CORDIC_STEPS-1] ? ang_x : '0;
         rsp_ay_ff   <= crot_ff[CORDIC_STEPS-1] ? ang_y : '0;
         rsp_az_ff   <= (crot_ff[CORDIC_STEPS-1] && !csing_ff[CORDIC_STEPS-1])
                        ? ang_z : '0;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.is_rotation = rsp_rot_ff;
   assign rsp_ch.singular    = rsp_sing_ff;
   assign rsp_ch.angle_x     = rsp_ax_ff;
   assign rsp_ch.angle_y     = rsp_ay_ff;
   assign rsp_ch.angle_z     = rsp_az_ff;

   `RMTE_ASSERT_IMP(a_reject_zero, rsp_valid_ff && !rsp_rot_ff, rsp_ax_ff == '0 && rsp_ay_ff == '0 && rsp_az_ff == '0 && !rsp_sing_ff, "rejected matrix has nonzero result")
   `RMTE_ASSERT_IMP(a_singular_z, rsp_valid_ff && rsp_sing_ff, rsp_rot_ff && rsp_az_ff == '0, "singular result has nonzero z angle")
   `RMTE_ASSERT_NEXT(a_hold_result, rsp_valid_ff && !rsp_ch.ready, rsp_valid_ff && $stable(rsp_ax_ff) && $stable(rsp_ay_ff) && $stable(rsp_az_ff), "held result changed")

endmodule

[dv/rotation_matrix_to_euler_angles_tb.sv]
// Testbench for the rotation-matrix-to-Euler block: directed table, random
// rotations and noise, checked field by field against an in-bench predictor.
// Depends on rmte_pkg, rmte_intf and the block's RTL.
`timescale 1ns / 1ps

module rotation_matrix_to_euler_angles_tb;
   import rmte_pkg::*;

   localparam int LATENCY = 62;

   typedef struct {
      logic                 is_rotation;
      logic                 singular;
      logic signed [AW-1:0] angle_x;
      logic signed [AW-1:0] angle_y;
      logic signed [AW-1:0] angle_z;
   } angles_type;

   typedef struct {
      elem_type   m[9];
      logic       known;  // expected angles typed in below
      angles_type ang;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmte_req_if req_ch ();
   rmte_rsp_if rsp_ch ();
   rmte_csr_if csr_ch ();

   rotation_matrix_to_euler_angles i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_ch(csr_ch.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #100ms;
      $display("rotation_matrix_to_euler_angles_tb: FAIL");
      $finish;
   end

   logic [TW-1:0] ortho_tol;
   logic [TW-1:0] sing_tol;
   angles_type    pending_angles[$];
   int            mismatch_count = 0;
   bit            quiet_phase    = 0;
   int            hold_off       = 0;

   // Floor shift on 64-bit signed values
   function automatic longint fshr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint acc, t, dx, dy;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; acc = 421657428;
         end else begin
            t = x; x = -y; y = t; acc = -421657428;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = fshr(y, i);
         dy = fshr(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; acc += longint'(atan_lut(i));
         end else begin
            x -= dx; y += dy; acc -= longint'(atan_lut(i));
         end
      end
      if (acc > 843314857) acc = 843314857;
      if (acc < -843314857) acc = -843314857;
      return acc;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v  -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic angles_type euler_angles(elem_type m[9]);
      angles_type      a;
      longint          r[3][3];
      longint unsigned err, sy2;
      longint          hi, lo, p, h, e, d, sy;
      err = 0;
      a   = '{default: '0};
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) r[i][j] = longint'(m[i*3+j]);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            hi = 0; lo = 0;
            for (int k = 0; k < 3; k++) begin
               p   = r[k][i] * r[k][j];
               h   = fshr(p, 30);
               hi += h;
               lo += p - h * 64'sd1073741824;
            end
            e = hi + ((lo + 64'sd536870912) >>> 30);
            d = e - ((i == j) ? 64'sd1073741824 : 64'sd0);
            if (d < 0) d = -d;
            if (d > 2097152) d = 2097152;
            err += longint'(d * d);
         end
      a.is_rotation = (err < ortho_tol);
      if (a.is_rotation) begin
         sy2 = longint'(r[0][0] * r[0][0]) + longint'(r[1][0] * r[1][0]);
         sy  = longint'(int_sqrt(sy2));
         a.singular = (sy2 < sing_tol);
         a.angle_y  = AW'(vector_angle(-r[2][0], sy));
         if (!a.singular) begin
            a.angle_x = AW'(vector_angle(r[2][1], r[2][2]));
            a.angle_z = AW'(vector_angle(r[1][0], r[0][0]));
         end else begin
            a.angle_x = AW'(vector_angle(-r[1][2], r[1][1]));
         end
      end
      return a;
   endfunction

   task automatic report(string what, longint got, longint want);
      mismatch_count++;
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   // Write one register, then step past the edge so writes never overlap
   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [TW-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_ORTHO_TOL) ortho_tol = val;
      else if (idx == CSR_SING_TOL) sing_tol = val;
      @(posedge clock);
   endtask

   // Wait for the pipeline to drain before touching registers
   task automatic drain();
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   // Send one matrix; optionally with a typed-in expectation
   task automatic send_matrix(elem_type m[9], logic known, angles_type ang);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.r00, req_ch.r01, req_ch.r02, req_ch.r10, req_ch.r11,
       req_ch.r12, req_ch.r20, req_ch.r21, req_ch.r22}
         <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
      do @(posedge clock); while (!req_ch.ready);
      pending_angles.insert(pending_angles.size(), known ? ang : euler_angles(m));
   endtask

   task automatic idle_input();
      req_ch.valid <= 1'b0;
   endtask

   // Rotation from three random angles, built in real arithmetic
   function automatic void rand_rotation(output elem_type m[9], input bit gimbal);
      real ax, ay, az, cx, sx, cy, sy, cz, sz, f[9];
      ax = ($urandom_range(0, 62831) - 31415) / 10000.0;
      ay = ($urandom_range(0, 62831) - 31415) / 10000.0;
      az = ($urandom_range(0, 62831) - 31415) / 10000.0;
      if (gimbal) ay = $urandom_range(0, 1) ? 1.5707963267948966 : -1.5707963267948966;
      cx = $cos(ax); sx = $sin(ax); cy = $cos(ay); sy = $sin(ay);
      cz = $cos(az); sz = $sin(az);
      f = '{cy*cz, sx*sy*cz - cx*sz, cx*sy*cz + sx*sz,
            cy*sz, sx*sy*sz + cx*cz, cx*sy*sz - sx*cz,
            -sy,   sx*cy,            cx*cy};
      for (int i = 0; i < 9; i++) begin
         m[i] = elem_type'(longint'($rtoi(f[i] * 1073741824.0)));
         if ($urandom_range(0, 3) == 0) m[i] += elem_type'($urandom_range(0, 6) - 3);
      end
   endfunction

   // Result side: random stalls, one long hold-off, field checks
   initial begin
      angles_type want;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (1) begin
         if (hold_off > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready && !reset) begin
            if (pending_angles.size() == 0) begin
               report("unexpected transaction", 0, 0);
            end else begin
               want = pending_angles.pop_front();
               if (rsp_ch.is_rotation !== want.is_rotation)
                  report("is_rotation", rsp_ch.is_rotation, want.is_rotation);
               if (rsp_ch.singular !== want.singular)
                  report("singular", rsp_ch.singular, want.singular);
               if (rsp_ch.angle_x !== want.angle_x)
                  report("angle_x", rsp_ch.angle_x, want.angle_x);
               if (rsp_ch.angle_y !== want.angle_y)
                  report("angle_y", rsp_ch.angle_y, want.angle_y);
               if (rsp_ch.angle_z !== want.angle_z)
                  report("angle_z", rsp_ch.angle_z, want.angle_z);
            end
         end
      end
   end

   initial begin
      localparam elem_type   ONE  = 32'sh4000_0000;
      localparam elem_type   MONE = -32'sh4000_0000;
      localparam elem_type   MAXV = 32'sh7fff_ffff;
      localparam elem_type   MINV = 32'sh8000_0000;
      localparam angles_type NOT_ROT = '{1'b0, 1'b0, '0, '0, '0};
      dir_row_type   rows[$];
      elem_type      m[9];
      logic [TW-1:0] tol_set[4];

      req_ch.valid = 1'b0;
      {req_ch.r00, req_ch.r01, req_ch.r02, req_ch.r10, req_ch.r11,
       req_ch.r12, req_ch.r20, req_ch.r21, req_ch.r22} = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data  = '0;
      ortho_tol = TOL_RESET;
      sing_tol  = TOL_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: identity, extremes, invalid, singular, negative axes
      rows.insert(rows.size(), '{'{ONE,0,0, 0,ONE,0, 0,0,ONE}, 0, NOT_ROT});
      rows.insert(rows.size(), '{'{0,0,0, 0,0,0, 0,0,0}, 1, NOT_ROT});
      rows.insert(rows.size(),
                  '{'{MAXV,MAXV,MAXV, MAXV,MAXV,MAXV, MAXV,MAXV,MAXV}, 1, NOT_ROT});
      rows.insert(rows.size(),
                  '{'{MINV,MINV,MINV, MINV,MINV,MINV, MINV,MINV,MINV}, 1, NOT_ROT});
      rows.insert(rows.size(),
                  '{'{MAXV,MINV,MAXV, MINV,MAXV,MINV, MAXV,MINV,MAXV}, 1, NOT_ROT});
      rows.insert(rows.size(), '{'{-1,-1,-1, -1,-1,-1, -1,-1,-1}, 1, NOT_ROT});
      rows.insert(rows.size(), '{'{0,0,ONE, 0,ONE,0, MONE,0,0}, 0, NOT_ROT});
      rows.insert(rows.size(), '{'{0,0,MONE, 0,ONE,0, ONE,0,0}, 0, NOT_ROT});
      rows.insert(rows.size(), '{'{0,ONE,0, 0,0,ONE, ONE,0,0}, 0, NOT_ROT});
      rows.insert(rows.size(), '{'{MONE,0,0, 0,MONE,0, 0,0,ONE}, 0, NOT_ROT});
      rows.insert(rows.size(), '{'{ONE,0,0, 0,MONE,0, 0,0,MONE}, 0, NOT_ROT});
      rows.insert(rows.size(), '{'{0,MONE,0, ONE,0,0, 0,0,ONE}, 0, NOT_ROT});
      rows.insert(rows.size(), '{'{0,ONE,0, MONE,0,0, 0,0,ONE}, 0, NOT_ROT});
      rows.insert(rows.size(), '{'{ONE,0,0, 0,0,MONE, 0,ONE,0}, 0, NOT_ROT});
      rows.insert(rows.size(), '{'{ONE+1,0,0, 0,ONE,0, 0,0,ONE-1}, 0, NOT_ROT});
      foreach (rows[i]) send_matrix(rows[i].m, rows[i].known, rows[i].ang);
      idle_input();
      drain();

      // Random phases over several tolerance settings, extremes included
      tol_set = '{'0, TOL_RESET, 40'hff_ffff_ffff, 40'd1 << 36};
      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            write_reg(CSR_ORTHO_TOL, ph == 4 ? 40'hff_ffff_ffff : tol_set[ph % 4]);
            write_reg(CSR_SING_TOL, ph == 2 ? 40'hff_ffff_ffff
                                            : tol_set[(ph + 1) % 4]);
         end
         if (ph == 1) hold_off = 300;
         quiet_phase = (ph == 4);
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(0, 9) < 7) begin
               rand_rotation(m, $urandom_range(0, 5) == 0);
            end else begin
               foreach (m[i]) m[i] = elem_type'($urandom);
            end
            send_matrix(m, 1'b0, NOT_ROT);
         end
         idle_input();
         drain();
      end

      if (mismatch_count == 0 && pending_angles.size() == 0) begin
         $display("rotation_matrix_to_euler_angles_tb: PASS");
      end else begin
         $display("rotation_matrix_to_euler_angles_tb: FAIL");
      end
      $finish;
   end

endmodule
